FILE: src/asob_pkg.sv
// shared constants and types for the sawtooth oscillator bank
`timescale 1ns / 1ps
package asob_pkg;
  localparam int VOICES_DEF     = 16;
  localparam int PHASE_BITS_DEF = 24;

  localparam int VOICE_W  = 4;
  localparam int SAMPLE_W = 24;
  localparam int INC_W    = 24;

  localparam int DEN_W = 53;
  localparam int NUM_W = 56;
  localparam int QUO_W = 24;

  localparam logic [23:0] SAW_HALF   = 24'd8388608;
  localparam logic [23:0] EDGE_START = 24'd6710886;
  localparam logic [27:0] T_MAX      = 28'd167772160;
  localparam logic [31:0] POLY_ONE   = 32'd1073741824;
  localparam logic [29:0] COEF1      = 30'd747394792;
  localparam logic [27:0] COEF2      = 28'd241048959;
  localparam logic [26:0] COEF3      = 27'd85298306;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
endpackage

FILE: src/asob_ifs.sv
// input and result channel interfaces
`timescale 1ns / 1ps
interface asob_in_if import asob_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VOICE_W-1:0] voice;
  logic [INC_W-1:0]   phase_increment;
  modport source (output valid, voice, phase_increment, input ready);
  modport sink   (input valid, voice, phase_increment, output ready);
endinterface

interface asob_out_if import asob_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VOICE_W-1:0] voice_out;
  sample_t            sample;
  modport source (output valid, voice_out, sample, input ready);
  modport sink   (input valid, voice_out, sample, output ready);
endinterface

FILE: src/asob_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module asob_div import asob_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] bits_r, bits_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, bits_r[QUO_W-1]};
    if (start) begin
      // upper part of the numerator is already below the divisor
      rem_nxt  = DEN_W'(num >> QUO_W);
      bits_nxt = num[QUO_W-1:0];
      quo_nxt  = '0;
      cnt_nxt  = 5'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(trial);
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      bits_nxt = {bits_r[QUO_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

FILE: src/antialiased_saw_oscillator_bank.sv
// sawtooth oscillator bank with smoothed wrap edges
//   channel | direction | fields
//   in_if   | sink      | voice, phase_increment
//   out_if  | source    | voice_out, sample
// an item passes from acceptance to result through these steps: memory read, window,
// three polynomial multiplies, denominator, divider start, 24 divider steps, final add.
// the 24-step divider sets the rate: one item in flight at a time.
// reset clears all phases through per-voice valid bits, no sweep needed.
// a result waiting in the output register stalls only the final step.
`timescale 1ns / 1ps
module antialiased_saw_oscillator_bank import asob_pkg::*; #(
  parameter int VOICES     = VOICES_DEF,
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  asob_in_if.sink    in_if,
  asob_out_if.source out_if
);
  localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int UP  = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
  localparam int DN  = (PHASE_BITS < 24) ? 24 - PHASE_BITS : 0;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_WIN  = 4'd2;
  localparam logic [3:0] ST_P1   = 4'd3;
  localparam logic [3:0] ST_P2   = 4'd4;
  localparam logic [3:0] ST_P3   = 4'd5;
  localparam logic [3:0] ST_DEN  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;
  localparam logic [3:0] ST_DST  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // voice number folded into the bank
  logic [SLOT_W-1:0] slot_lut [16];
  for (genvar g = 0; g < 16; g++) begin : g_lut
    assign slot_lut[g] = SLOT_W'(g % VOICES);
  end

  logic [PHASE_BITS-1:0] phase_mem [VOICES];
  logic [VOICES-1:0]     vld_r;
  logic [PHASE_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;

  logic                  in_acc;
  logic [SLOT_W-1:0]     in_slot;
  logic [SLOT_W-1:0]     slot_r;
  logic [VOICE_W-1:0]    voice_r;
  logic [PHASE_BITS-1:0] inc_r;
  logic [PHASE_BITS-1:0] ph_new;
  logic [23:0]           p24;

  logic signed [24:0] s_r;
  logic [23:0]        d_r;
  logic [22:0]        f_r;
  logic [4:0]         n_r;
  logic [31:0]        acc_r;
  logic [DEN_W-1:0]   den_r;

  logic [24:0]  mag;
  logic [24:0]  d_full;
  logic [31:0]  w;
  logic [28:0]  t;
  logic [27:0]  t_cl;
  logic [57:0]  prod;
  logic [31:0]  poly;

  logic             div_start, div_done;
  logic [QUO_W-1:0] quo;
  logic [NUM_W-1:0] num;

  logic signed [25:0] fin;
  sample_t            fin_sat;
  logic               out_valid_r;
  logic [VOICE_W-1:0] out_voice_r;
  sample_t            out_sample_r;
  logic               fin_go;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign in_slot     = slot_lut[in_if.voice];

  assign ph_new = PHASE_BITS'((rd_vld_r ? rd_data_r : '0) + inc_r);
  assign p24    = 24'((33'(ph_new) >> UP) << DN);

  assign mag    = s_r[24] ? 25'(-s_r) : 25'(s_r);
  assign d_full = (mag > 25'(EDGE_START)) ? mag - 25'(EDGE_START) : '0;
  assign w      = 32'(d_r) * 32'd100;
  assign t      = 29'(T_MAX) - 29'(w);
  assign t_cl   = t[28] ? '0 : t[27:0];

  always_comb begin
    case (state_r)
      ST_P1:   prod = 58'(COEF3) * 58'(f_r);
      default: prod = 58'(acc_r) * 58'(f_r);
    endcase
  end

  assign div_start = (state_r == ST_DST);
  assign num       = (NUM_W'(1) << 54) + NUM_W'(den_r >> 1);

  assign fin     = s_r[24] ? 26'(s_r) + 26'(quo) : 26'(s_r) - 26'(quo);
  assign fin_sat = (fin > 26'sd8388607) ? sample_t'(24'h7FFFFF) :
                   (fin < -26'sd8388608) ? sample_t'(24'h800000) : fin[23:0];
  assign fin_go  = (state_r == ST_FIN) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WIN;
      ST_WIN:  state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DST;
      ST_DST:  state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RD) vld_r[slot_r] <= 1'b1;
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // phase memory: read on acceptance, written back in the next cycle (the read state)
  always_ff @(posedge clk) begin
    if (in_acc) rd_data_r <= phase_mem[in_slot];
    if (state_r == ST_RD) phase_mem[slot_r] <= ph_new;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r   <= in_slot;
      voice_r  <= in_if.voice;
      inc_r    <= PHASE_BITS'((32'(in_if.phase_increment) << UP) >> DN);
      rd_vld_r <= vld_r[in_slot];
    end
    case (state_r)
      ST_RD:  s_r <= $signed({1'b0, p24}) - $signed({1'b0, SAW_HALF});
      ST_WIN: d_r <= 24'(d_full);
      ST_P1: begin
        n_r   <= (t_cl[27:23] > 5'd20) ? 5'd20 : t_cl[27:23];
        f_r   <= t_cl[22:0];
        acc_r <= 32'(COEF3);
      end
      ST_P2:   acc_r <= 32'(COEF2) + 32'(prod >> 23);
      ST_P3:   acc_r <= 32'(COEF1) + 32'(prod >> 23);
      ST_DEN:  acc_r <= acc_r;
      default: acc_r <= acc_r;
    endcase
    if (fin_go) begin
      out_voice_r  <= voice_r;
      out_sample_r <= fin_sat;
    end
  end

  // final Horner product, then the denominator
  logic [31:0] acc3;
  assign acc3 = 32'(prod >> 23);
  assign poly = POLY_ONE + acc3;
  always_ff @(posedge clk) begin
    if (state_r == ST_DEN) den_r <= DEN_W'(POLY_ONE) + (DEN_W'(poly) << n_r);
  end

  asob_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign out_if.valid     = out_valid_r;
  assign out_if.voice_out = out_voice_r;
  assign out_if.sample    = out_sample_r;

`ifndef SYNTHESIS
  a_acc_rd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_RD)
    else $error("accepted transaction did not start a read");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> quo <= QUO_W'(SAW_HALF))
    else $error("edge correction exceeds half scale");
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("result register not loaded");
`endif
endmodule
